>>> sv/sha5ps_pkg.sv
// Shared types, constants and sigma functions for the SHA-512 padding and
// message schedule block. No dependencies.
package sha5ps_pkg;

	localparam int BLOCK_BYTES  = 128;
	localparam int BLOCK_WORDS  = 16;
	localparam int LENGTH_START = 112;
	localparam int SCHED_WORDS  = 80;
	localparam int WORD_FIELDS  = 4;
	localparam int IDX_W        = 7;
	localparam int POS_W        = 7;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [63:0] word_t;
	typedef word_t [BLOCK_WORDS-1:0] block_t;

	// handoff of a packed block into the schedule chain
	typedef struct packed {
		logic load;
		logic last;
	} load_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

endpackage

>>> sv/sha5ps_cell.sv
// One 64-bit stage of the schedule window chain.
// Depends on sha5ps_pkg for the word type.
module sha5ps_cell (
	input  logic              clk,
	input  logic              load,
	input  logic              shift_en,
	input  sha5ps_pkg::word_t load_word,
	input  sha5ps_pkg::word_t next_word,
	output sha5ps_pkg::word_t word
);

	sha5ps_pkg::word_t word_q;

	// take the block word on load, else the neighbor's word on a step
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end else if (shift_en) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

>>> sv/sha5ps_sched.sv
// Message schedule: a chain of sixteen window cells with the sigma feedback,
// word grouping and the output register. Depends on sha5ps_pkg, sha5ps_cell.
module sha5ps_sched #(
	parameter int WORDS_PER_RESULT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sha5ps_pkg::load_t                ld,
	input  sha5ps_pkg::block_t               blk,
	output logic                             busy,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [63:0]                      word_a,
	output logic [63:0]                      word_b,
	output logic [63:0]                      word_c,
	output logic [63:0]                      word_d,
	output logic [sha5ps_pkg::IDX_W-1:0]     word_index,
	output logic                             block_done,
	output logic                             message_done
);

	localparam int SLOT_W = (WORDS_PER_RESULT > 1) ? $clog2(WORDS_PER_RESULT) : 1;
	localparam int IW     = sha5ps_pkg::IDX_W;

	sha5ps_pkg::word_t [sha5ps_pkg::BLOCK_WORDS-1:0] win;
	sha5ps_pkg::word_t                               feedback;
	sha5ps_pkg::word_t [sha5ps_pkg::WORD_FIELDS-1:0] acc_q;
	sha5ps_pkg::word_t [sha5ps_pkg::WORD_FIELDS-1:0] res;

	logic              busy_q;
	logic              last_q;
	logic [IW-1:0]     t_q;
	logic [SLOT_W-1:0] slot_q;
	logic              step;
	logic              last_word;
	logic              res_done;

	logic              out_valid_q;
	sha5ps_pkg::word_t [sha5ps_pkg::WORD_FIELDS-1:0] out_words_q;
	logic [IW-1:0]     out_index_q;
	logic              out_block_q;
	logic              out_msg_q;

	// next schedule word from the current window W[t..t+15]
	assign feedback = sha5ps_pkg::small_sigma1(win[14]) + win[9]
		+ sha5ps_pkg::small_sigma0(win[1]) + win[0];

	// build the row of window cells, oldest word in cell zero
	for (genvar i = 0; i < sha5ps_pkg::BLOCK_WORDS; i++) begin : g_cell
		sha5ps_pkg::word_t next_w;
		if (i == sha5ps_pkg::BLOCK_WORDS - 1) begin : g_tail
			assign next_w = feedback;
		end else begin : g_link
			assign next_w = win[i+1];
		end
		sha5ps_cell u_cell (
			.clk       (clk),
			.load      (ld.load),
			.shift_en  (step),
			.load_word (blk[i]),
			.next_word (next_w),
			.word      (win[i])
		);
	end

	// advance only while the output register can take a finished result
	assign step      = busy_q && (!out_valid_q || !out_stall);
	assign last_word = (t_q == IW'(sha5ps_pkg::SCHED_WORDS - 1));
	assign res_done  = step && (slot_q == SLOT_W'(WORDS_PER_RESULT - 1) || last_word);

	// assemble the result: earlier slots, the current word, zeros beyond
	always_comb begin
		for (int k = 0; k < sha5ps_pkg::WORD_FIELDS; k++) begin
			if (k < int'(slot_q)) begin
				res[k] = acc_q[k];
			end else if (k == int'(slot_q)) begin
				res[k] = win[0];
			end else begin
				res[k] = '0;
			end
		end
	end

	// hold the words of a result in progress
	always_ff @(posedge clk) begin
		for (int k = 0; k < sha5ps_pkg::WORD_FIELDS; k++) begin
			if (step && int'(slot_q) == k) begin
				acc_q[k] <= win[0];
			end
		end
	end

	// sequence the 80 steps of one block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_q <= 1'b0;
			t_q    <= '0;
			slot_q <= '0;
		end else if (ld.load) begin
			busy_q <= 1'b1;
			last_q <= ld.last;
			t_q    <= '0;
			slot_q <= '0;
		end else if (step) begin
			if (last_word) begin
				busy_q <= 1'b0;
				t_q    <= '0;
			end else begin
				t_q <= t_q + IW'(1);
			end
			if (res_done) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	// output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			out_words_q <= res;
			out_index_q <= t_q - IW'(slot_q);
			out_block_q <= last_word;
			out_msg_q   <= last_word && last_q;
		end
	end

	assign busy         = busy_q;
	assign out_valid    = out_valid_q;
	assign word_a       = out_words_q[0];
	assign word_b       = out_words_q[1];
	assign word_c       = out_words_q[2];
	assign word_d       = out_words_q[3];
	assign word_index   = out_index_q;
	assign block_done   = out_block_q;
	assign message_done = out_msg_q;

endmodule

>>> sv/sha5ps_pad.sv
// Byte packing, bit length count and padding into 1024-bit blocks.
// Depends on sha5ps_pkg.
module sha5ps_pad (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               has_byte,
	input  logic               end_of_message,
	input  logic               sched_busy,
	output sha5ps_pkg::load_t  ld,
	output sha5ps_pkg::block_t blk
);

	localparam int PW = sha5ps_pkg::POS_W;
	localparam int LB = sha5ps_pkg::BLOCK_BYTES - 8;

	logic [sha5ps_pkg::BLOCK_BYTES-1:0][7:0] bytes_q;
	logic [sha5ps_pkg::BLOCK_BYTES-1:0][7:0] tail_bytes;
	logic [PW-1:0] pos_q;
	logic [63:0]   len_q;
	logic          req_q;
	logic          last_q;
	logic          tail_q;
	logic          tail_pad_q;

	logic          accept;
	logic          full;
	logic          two;
	logic [PW-1:0] pad_pos;
	logic [63:0]   len_n;

	assign in_stall = req_q;
	assign accept   = in_valid && !req_q;
	assign full     = has_byte && (pos_q == PW'(sha5ps_pkg::BLOCK_BYTES - 1));
	assign pad_pos  = has_byte ? pos_q + PW'(1) : pos_q;
	assign two      = end_of_message && !full && (pad_pos >= PW'(sha5ps_pkg::LENGTH_START));
	assign len_n    = len_q + (has_byte ? 64'd8 : 64'd0);

	assign ld.load = req_q && !sched_busy;
	assign ld.last = last_q;

	// regroup bytes into big-endian words
	always_comb begin
		for (int w = 0; w < sha5ps_pkg::BLOCK_WORDS; w++) begin
			for (int b = 0; b < 8; b++) begin
				blk[w][63-8*b -: 8] = bytes_q[8*w+b];
			end
		end
	end

	// build the length-only tail block, with the pad marker when the message filled a block
	always_comb begin
		tail_bytes = '0;
		if (tail_pad_q) begin
			tail_bytes[0] = sha5ps_pkg::PAD_BYTE;
		end
		for (int k = 0; k < 8; k++) begin
			tail_bytes[LB+k] = len_q[63-8*k -: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q    <= '0;
			pos_q      <= '0;
			len_q      <= '0;
			req_q      <= 1'b0;
			last_q     <= 1'b0;
			tail_q     <= 1'b0;
			tail_pad_q <= 1'b0;
		end else if (ld.load) begin
			// hand the block over, then build the length-only tail if one is due
			if (tail_q) begin
				bytes_q <= tail_bytes;
				last_q  <= 1'b1;
				tail_q  <= 1'b0;
			end else begin
				bytes_q <= '0;
				req_q   <= 1'b0;
				if (last_q) begin
					len_q <= '0;
				end
			end
		end else if (accept) begin
			// place the byte and the pad marker
			for (int i = 0; i < sha5ps_pkg::BLOCK_BYTES; i++) begin
				if (has_byte && pos_q == PW'(i)) begin
					bytes_q[i] <= data_byte;
				end else if (end_of_message && !full && pad_pos == PW'(i)) begin
					bytes_q[i] <= sha5ps_pkg::PAD_BYTE;
				end
			end
			if (end_of_message && !full && !two) begin
				for (int k = 0; k < 8; k++) begin
					bytes_q[LB+k] <= len_n[63-8*k -: 8];
				end
			end
			len_q <= len_n;
			priority if (end_of_message) begin
				pos_q      <= '0;
				req_q      <= 1'b1;
				last_q     <= !(full || two);
				tail_q     <= full || two;
				tail_pad_q <= full;
			end else if (full) begin
				pos_q  <= '0;
				req_q  <= 1'b1;
				last_q <= 1'b0;
			end else if (has_byte) begin
				pos_q <= pos_q + PW'(1);
			end else begin
				// idle transaction: hold the byte slot
				pos_q <= pos_q;
			end
		end
	end

endmodule

>>> sv/sha512_pad_and_schedule.sv
// Timing: a block that an input transaction completes is handed from the pad buffer into
// the cell chain, which steps out one schedule word per cycle while the output register
// can take a result; each group of up to WORDS_PER_RESULT words is registered as a result.
// Throughput: one byte per cycle, but input stalls while a completed block waits for its
// handoff, longer while a second padded block waits for the chain or results stall.
// Reset clears control state, counters and the block buffer at once.
module sha512_pad_and_schedule #(
	parameter int WORDS_PER_RESULT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] word_a,
	output logic [63:0] word_b,
	output logic [63:0] word_c,
	output logic [63:0] word_d,
	output logic [6:0]  word_index,
	output logic        block_done,
	output logic        message_done
);

	sha5ps_pkg::load_t  ld;
	sha5ps_pkg::block_t blk;
	logic               sched_busy;

	sha5ps_pad u_pad (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.sched_busy     (sched_busy),
		.ld             (ld),
		.blk            (blk)
	);

	sha5ps_sched #(
		.WORDS_PER_RESULT (WORDS_PER_RESULT)
	) u_sched (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld),
		.blk          (blk),
		.busy         (sched_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.word_a       (word_a),
		.word_b       (word_b),
		.word_c       (word_c),
		.word_d       (word_d),
		.word_index   (word_index),
		.block_done   (block_done),
		.message_done (message_done)
	);

`ifndef ASSERT_OFF
	// a handed-over block starts the chain
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |=> sched_busy)
		else $error("schedule chain not busy after block load");

	// the final block of a message is also the end of a block
	a_msg_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && message_done) |-> block_done)
		else $error("message_done without block_done");

	// a pending block leaves the byte slot at zero
	a_pos_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		u_pad.req_q |-> (u_pad.pos_q == '0))
		else $error("byte position not cleared with a block pending");

	// a tail block is only due behind a pending block
	a_tail_pending: assert property (@(posedge clk) disable iff (!arst_n)
		u_pad.tail_q |-> u_pad.req_q)
		else $error("tail block without pending handoff");
`endif

endmodule

>>> dv/sha512_sched_sb_pkg.sv
// Scoreboard for the SHA-512 padding and message schedule block: a byte-level
// predictor of padding and schedule expansion plus an in-order result check.
// Depends on sha5ps_pkg for word types and block constants.
package sha512_sched_sb_pkg;

	import sha5ps_pkg::*;

	localparam int RESULT_WORDS    = 4;
	localparam int BEATS_PER_BLOCK = (SCHED_WORDS + RESULT_WORDS - 1) / RESULT_WORDS;

	// one output transaction as seen on the result channel
	typedef struct packed {
		logic [WORD_FIELDS-1:0][63:0] words;
		logic [IDX_W-1:0]             index;
		logic                         blk_end;
		logic                         msg_end;
	} sched_beat_t;

	class schedule_scoreboard;

		word_t       msg_block [BLOCK_WORDS];
		int unsigned fill_bytes;
		word_t       length_bits;
		sched_beat_t expected_beats [$];
		int unsigned mismatches;
		int unsigned beats_checked;
		int unsigned blocks_expanded;
		int unsigned messages_closed;

		function new();
			clear_block();
			length_bits     = '0;
			mismatches      = 0;
			beats_checked   = 0;
			blocks_expanded = 0;
			messages_closed = 0;
		endfunction

		function void clear_block();
			foreach (msg_block[i])
				msg_block[i] = '0;
			fill_bytes = 0;
		endfunction

		function word_t ror(word_t x, int unsigned n);
			logic [127:0] dbl;
			dbl = {x, x} >> n;
			return dbl[63:0];
		endfunction

		function word_t sig0(word_t x);
			return ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
		endfunction

		function word_t sig1(word_t x);
			return ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
		endfunction

		// pack big-endian: first byte of a word lands in its top byte
		function void place_byte(logic [7:0] b);
			msg_block[fill_bytes / 8][63 - 8 * (fill_bytes % 8) -: 8] = b;
			fill_bytes++;
		endfunction

		// expand the current block into 80 words and queue its result beats
		function void expand_schedule(bit closes_message);
			word_t       sched [SCHED_WORDS];
			sched_beat_t beat;
			int unsigned t;
			for (int unsigned i = 0; i < SCHED_WORDS; i++) begin
				if (i < BLOCK_WORDS)
					sched[i] = msg_block[i];
				else
					sched[i] = sig1(sched[i-2]) + sched[i-7] + sig0(sched[i-15]) + sched[i-16];
			end
			for (int unsigned r = 0; r < BEATS_PER_BLOCK; r++) begin
				beat = '0;
				for (int unsigned j = 0; j < WORD_FIELDS; j++) begin
					t = r * RESULT_WORDS + j;
					if (j < RESULT_WORDS && t < SCHED_WORDS)
						beat.words[j] = sched[t];
				end
				beat.index   = IDX_W'(r * RESULT_WORDS);
				beat.blk_end = (r == BEATS_PER_BLOCK - 1);
				beat.msg_end = beat.blk_end && closes_message;
				expected_beats.push_back(beat);
			end
			blocks_expanded++;
		endfunction

		// note one accepted input transaction and queue what it produces
		function void absorb(logic [7:0] data, logic has_byte, logic eom);
			if (has_byte) begin
				place_byte(data);
				length_bits += 64'd8;
				if (fill_bytes >= BLOCK_BYTES) begin
					expand_schedule(1'b0);
					clear_block();
				end
			end
			if (eom) begin
				place_byte(PAD_BYTE);
				// no room left for the length: flush and pad a second block
				if (fill_bytes > LENGTH_START) begin
					expand_schedule(1'b0);
					clear_block();
				end
				msg_block[BLOCK_WORDS-2] = '0;
				msg_block[BLOCK_WORDS-1] = length_bits;
				expand_schedule(1'b1);
				clear_block();
				length_bits = '0;
				messages_closed++;
			end
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				if (mismatches < 10)
					$display("  %s at result %0d: expected %h, got %h",
						name, beats_checked, want, got);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// compare one accepted result against the oldest expectation
		function void compare(sched_beat_t got);
			sched_beat_t want;
			bit          bad;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				if (mismatches < 10)
					$display("  unexpected result %0d: index %0d", beats_checked, got.index);
				mismatches++;
				return;
			end
			want = expected_beats.pop_front();
			bad  = 1'b0;
			for (int j = 0; j < WORD_FIELDS; j++)
				bad |= field_differs($sformatf("word %0d", j), want.words[j], got.words[j]);
			bad |= field_differs("word_index", 64'(want.index), 64'(got.index));
			bad |= field_differs("block_done", 64'(want.blk_end), 64'(got.blk_end));
			bad |= field_differs("message_done", 64'(want.msg_end), 64'(got.msg_end));
			if (bad)
				mismatches++;
		endfunction

	endclass

endpackage

>>> dv/tb_sha512_pad_and_schedule.sv
// Top-level testbench for sha512_pad_and_schedule: drives message bytes with
// random gaps, stalls the result side, and checks every schedule result.
// Depends on sha5ps_pkg and sha512_sched_sb_pkg.
module tb_sha512_pad_and_schedule;

	timeunit 1ns;
	timeprecision 1ps;

	import sha5ps_pkg::*;
	import sha512_sched_sb_pkg::*;

	localparam int unsigned RUN_LIMIT    = 200000;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned HOLD_CYCLES  = 500;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte      = 8'h00;
	logic        has_byte       = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [63:0] word_a;
	logic [63:0] word_b;
	logic [63:0] word_c;
	logic [63:0] word_d;
	logic [6:0]  word_index;
	logic        block_done;
	logic        message_done;

	logic        hold_off       = 1'b0;
	int unsigned items_sent     = 0;
	int unsigned cycle_count    = 0;

	schedule_scoreboard sb = new();

	sha512_pad_and_schedule #(
		.WORDS_PER_RESULT(RESULT_WORDS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.has_byte      (has_byte),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.word_a        (word_a),
		.word_b        (word_b),
		.word_c        (word_c),
		.word_d        (word_d),
		.word_index    (word_index),
		.block_done    (block_done),
		.message_done  (message_done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// offer one transaction and hold it until accepted
	task automatic send_item(input logic [7:0] data, input logic has, input logic eom,
			input bit burst);
		int unsigned gap;
		gap = burst ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= data;
		has_byte       <= has;
		end_of_message <= eom;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.absorb(data, has, eom);
		items_sent++;
	endtask

	// one message of random bytes, closed on its last byte or by an empty end
	task automatic send_message(input int unsigned len, input bit empty_end);
		bit burst;
		burst = 1'b0;
		for (int unsigned i = 0; i < len; i++) begin
			if (i % 32 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if (!burst && $urandom_range(0, 19) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst);
			send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_end, burst);
		end
		if (empty_end || len == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst);
	endtask

	// check results and drive the receiver stall pattern
	initial begin
		int unsigned stall_left;
		int unsigned free_left;
		sched_beat_t got;
		stall_left = 0;
		free_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.words   = {word_d, word_c, word_b, word_a};
				got.index   = word_index;
				got.blk_end = block_done;
				got.msg_end = message_done;
				sb.compare(got);
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (free_left > 0) begin
				out_stall <= 1'b0;
				free_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 99) < 35)
					free_left = $urandom_range(8, 60);
				else
					stall_left = pick_gap();
			end
		end
	end

	// hold off the receiver for a long stretch inside the long message
	initial begin
		while (items_sent < 60) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// end the run if it never drains
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, idle transaction, extreme bytes, short messages
		send_item(8'h00, 1'b0, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0, 1'b1);
		send_item(8'h7F, 1'b1, 1'b0, 1'b1);
		send_item(8'h01, 1'b1, 1'b1, 1'b1);
		send_item(8'hC3, 1'b0, 1'b0, 1'b0);

		// long message closed on the last byte of a full block: tail block with the pad marker
		send_message(128, 1'b0);

		// long message whose pad leaves no room for the length: two padded blocks
		send_message($urandom_range(112, 118), 1'($urandom_range(0, 1)));

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d input transactions, %0d messages, %0d schedule blocks.",
			items_sent, sb.messages_closed, sb.blocks_expanded);
		$display("Checked %0d results, %0d mismatched.", sb.beats_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
